/* rtl/hts_pkg.sv */
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types and constants of the terrain height sampler.
// ----------------------------------------------------------------------------
package hts_pkg;

  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned COORD_W    = 17;
  localparam int unsigned FRAC_MAX   = 16;
  localparam int unsigned CFG_W      = 9;
  localparam int unsigned HEIGHT_W   = 16;
  localparam int unsigned CORNER_W   = 18;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned STORE_DEPTH = 65536;

  // scaled height before the final divide by 257 stays below 2^25
  localparam int unsigned U_W        = 25;
  localparam int unsigned RECIP_W    = 26;
  localparam int unsigned RECIP_SHIFT = 33;
  localparam int unsigned Q_W        = 18;
  // floor(2^33 / 257), the estimate is never above the true quotient
  localparam logic [RECIP_W-1:0] RECIP_257 = 26'd33423870;
  localparam logic [8:0] DIV_257      = 9'd257;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 16'd65280;
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  typedef enum logic {
    CFG_MAP_WIDTH  = 1'b0,
    CFG_MAP_LENGTH = 1'b1
  } cfg_idx_e;

  // one classified item as it waits between front and back
  typedef struct packed {
    req_e                kind;
    logic                outside;
    logic                odd_row;
    logic [ADDR_W-1:0]   addr_bl;
    logic [ADDR_W-1:0]   addr_br;
    logic [ADDR_W-1:0]   addr_tl;
    logic [ADDR_W-1:0]   addr_tr;
    logic [SAMPLE_W-1:0] wdata;
    logic [FRAC_MAX-1:0] xf;
    logic [FRAC_MAX-1:0] zf;
  } hts_item_t;

endpackage

/* rtl/heightmap_triangle_height_sampler_unit.sv */
// ----------------------------------------------------------------------------
// heightmap_triangle_height_sampler_unit
// Terrain height map store with triangle-split bilinear height queries.
// ----------------------------------------------------------------------------
// Takes one beat per clock, writes and queries alike, while the input queue
// has room, and returns one result per query; writes give no result. A query
// passes from the input queue through the store read and the blend stages to
// the output register. The rate is set by the four copies of the sample
// store, each giving one corner per cycle, and the blend runs as a five-stage
// pipeline behind them. A stalled result freezes the whole pipeline. A
// four-entry queue sits between classification and the pipeline, so up to
// four input beats are still taken while a result waits on the output.
// Samples must be written before a query reads them; the user must write
// configuration only while the block is idle; the block does not enforce it.
module heightmap_triangle_height_sampler_unit #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_LENGTH = 256,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [8:0]  cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // sample_index, sample_raw, x_coord, z_coord
  input  logic        s_axis_tuser,  // req_type
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // height_q8
  output logic        m_axis_tuser   // outside
);
  import hts_pkg::*;

  logic [CFG_W-1:0] map_width_q, map_length_q;
  hts_item_t        front_item, head_item;
  logic             fifo_full, fifo_vld, pop;
  req_e             kind;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= CFG_RESET;
      map_length_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_MAP_WIDTH:  map_width_q  <= cfg_wdata_i;
        CFG_MAP_LENGTH: map_length_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign kind          = req_e'(s_axis_tuser);
  assign s_axis_tready = ~fifo_full;

  // front: classify the beat
  hts_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_LENGTH(MAX_LENGTH), .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .map_width_i   (map_width_q),
    .map_length_i  (map_length_q),
    .kind_i        (kind),
    .sample_index_i(s_axis_tdata[15:0]),
    .sample_raw_i  (s_axis_tdata[31:16]),
    .x_coord_i     (s_axis_tdata[48:32]),
    .z_coord_i     (s_axis_tdata[65:49]),
    .item_o        (front_item)
  );

  // queue between front and back
  hts_fifo #(.DEPTH(4)) u_fifo (
    .clk_i, .rst_ni,
    .push_i     (s_axis_tvalid),
    .push_item_i(front_item),
    .full_o     (fifo_full),
    .pop_i      (pop),
    .vld_o      (fifo_vld),
    .head_o     (head_item)
  );

  // back: store access and interpolation
  hts_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .item_vld_i(fifo_vld),
    .item_i    (head_item),
    .pop_o     (pop),
    .res_vld_o (m_axis_tvalid),
    .res_rdy_i (m_axis_tready),
    .height_o  (m_axis_tdata),
    .outside_o (m_axis_tuser)
  );

endmodule

/* rtl/hts_ram.sv */
// ----------------------------------------------------------------------------
// hts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hts_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* rtl/hts_fifo.sv */
// ----------------------------------------------------------------------------
// hts_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module hts_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hts_pkg::hts_item_t push_item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              vld_o,
  output hts_pkg::hts_item_t head_o
);
  import hts_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  hts_item_t       slots_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign vld_o   = (count_q != '0);
  assign head_o  = slots_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & vld_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* rtl/hts_front.sv */
// ----------------------------------------------------------------------------
// hts_front
// Classifies a beat: write or query, inside test and corner addresses.
// ----------------------------------------------------------------------------
module hts_front #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_LENGTH = 256,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic [hts_pkg::CFG_W-1:0]    map_width_i,
  input  logic [hts_pkg::CFG_W-1:0]    map_length_i,
  input  hts_pkg::req_e                kind_i,
  input  logic [hts_pkg::ADDR_W-1:0]   sample_index_i,
  input  logic [hts_pkg::SAMPLE_W-1:0] sample_raw_i,
  input  logic [hts_pkg::COORD_W-1:0]  x_coord_i,
  input  logic [hts_pkg::COORD_W-1:0]  z_coord_i,
  output hts_pkg::hts_item_t           item_o
);
  import hts_pkg::*;

  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned LW   = $clog2(MAX_LENGTH + 1);
  localparam int unsigned XI_W = COORD_W - FRAC_BITS;

  logic [WW-1:0]     w_eff;
  logic [LW-1:0]     l_eff;
  logic [XI_W-1:0]   xi, zi;
  logic              outside;
  logic [31:0]       row_off;
  logic [ADDR_W-1:0] base, above;

  // saturate the map size to the built maximum
  assign w_eff = (32'(map_width_i) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(map_width_i);
  assign l_eff = (32'(map_length_i) > MAX_LENGTH) ? LW'(MAX_LENGTH) : LW'(map_length_i);

  // integer cell coordinates
  assign xi = x_coord_i[COORD_W-1:FRAC_BITS];
  assign zi = z_coord_i[COORD_W-1:FRAC_BITS];

  // inside test, negative coordinates caught by the sign bit
  assign outside = (w_eff < WW'(2)) | (l_eff < LW'(2)) |
                   x_coord_i[COORD_W-1] | z_coord_i[COORD_W-1] |
                   (32'(xi) >= 32'(w_eff) - 32'd1) |
                   (32'(zi) >= 32'(l_eff) - 32'd1);

  // linear corner addresses, wrapping at the store depth
  assign row_off = 32'(zi) * 32'(w_eff);
  assign base    = ADDR_W'(32'(xi) + row_off);
  assign above   = base + ADDR_W'(w_eff);

  always_comb begin
    item_o         = '0;
    item_o.kind    = kind_i;
    item_o.wdata   = sample_raw_i;
    item_o.outside = outside;
    item_o.odd_row = z_coord_i[FRAC_BITS];
    item_o.xf      = FRAC_MAX'(x_coord_i[FRAC_BITS-1:0]);
    item_o.zf      = FRAC_MAX'(z_coord_i[FRAC_BITS-1:0]);
    item_o.addr_br = base + 1'b1;
    item_o.addr_tl = above;
    item_o.addr_tr = above + 1'b1;
    item_o.addr_bl = (kind_i == REQ_WRITE) ? sample_index_i : base;
  end

endmodule

/* rtl/hts_back.sv */
// ----------------------------------------------------------------------------
// hts_back
// Corner reads, triangle split, bilinear blend and 8.8 scaling pipeline.
// ----------------------------------------------------------------------------
module hts_back #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         item_vld_i,
  input  hts_pkg::hts_item_t           item_i,
  output logic                         pop_o,
  output logic                         res_vld_o,
  input  logic                         res_rdy_i,
  output logic [hts_pkg::HEIGHT_W-1:0] height_o,
  output logic                         outside_o
);
  import hts_pkg::*;

  localparam int unsigned WT_W = FRAC_BITS + 1;
  localparam int unsigned TW   = CORNER_W + FRAC_BITS + 3;
  localparam int unsigned HW   = TW + FRAC_BITS + 3;
  localparam int unsigned PR_W = U_W + RECIP_W;
  localparam logic [WT_W-1:0] SCALE = WT_W'(1) << FRAC_BITS;

  logic adv, re, we;
  logic [SAMPLE_W-1:0] rd_bl, rd_br, rd_tl, rd_tr;

  // pipeline advances unless a result sits untaken
  assign adv   = ~(res_vld_o & ~res_rdy_i);
  assign pop_o = adv & item_vld_i;
  assign re    = pop_o & (item_i.kind == REQ_QUERY);
  assign we    = pop_o & (item_i.kind == REQ_WRITE);

  // four copies of the store so all corners read in the same cycle
  hts_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_ram_bl (
    .clk_i, .we_i(we), .waddr_i(item_i.addr_bl), .wdata_i(item_i.wdata),
    .re_i(re), .raddr_i(item_i.addr_bl), .rdata_o(rd_bl));
  hts_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_ram_br (
    .clk_i, .we_i(we), .waddr_i(item_i.addr_bl), .wdata_i(item_i.wdata),
    .re_i(re), .raddr_i(item_i.addr_br), .rdata_o(rd_br));
  hts_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_ram_tl (
    .clk_i, .we_i(we), .waddr_i(item_i.addr_bl), .wdata_i(item_i.wdata),
    .re_i(re), .raddr_i(item_i.addr_tl), .rdata_o(rd_tl));
  hts_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_ram_tr (
    .clk_i, .we_i(we), .waddr_i(item_i.addr_bl), .wdata_i(item_i.wdata),
    .re_i(re), .raddr_i(item_i.addr_tr), .rdata_o(rd_tr));

  // stage valids
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  // stage payloads
  logic                       out1_q, out2_q, out3_q, out4_q, out5_q;
  logic                       odd1_q;
  logic [FRAC_BITS-1:0]       xf1_q, zf1_q, xf2_q, zf2_q, zf3_q;
  logic signed [CORNER_W-1:0] bl2_q, br2_q, tl2_q, tr2_q;
  logic signed [TW-1:0]       top3_q, bot3_q;
  logic signed [HW-1:0]       h4_q;
  logic [U_W-1:0]             u5_q;
  logic [PR_W-1:0]            prod5_q;

  // corner split logic
  logic signed [CORNER_W-1:0] bl, br, tl, tr;
  logic [WT_W-1:0]            fsum;
  always_comb begin
    bl   = $signed({2'b00, rd_bl});
    br   = $signed({2'b00, rd_br});
    tl   = $signed({2'b00, rd_tl});
    tr   = $signed({2'b00, rd_tr});
    fsum = WT_W'(xf1_q) + WT_W'(zf1_q);
    if (odd1_q) begin
      if (zf1_q >= xf1_q) begin
        br = bl + (tr - tl);
      end else begin
        tl = tr + (bl - br);
      end
    end else begin
      if (fsum < SCALE) begin
        tr = tl + (br - bl);
      end else begin
        bl = tl + (br - tr);
      end
    end
  end

  // blend weights
  logic signed [WT_W:0] wx0, wx1, wz0, wz1;
  assign wx1 = $signed({1'b0, WT_W'(xf2_q)});
  assign wx0 = $signed({1'b0, SCALE - WT_W'(xf2_q)});
  assign wz1 = $signed({1'b0, WT_W'(zf3_q)});
  assign wz0 = $signed({1'b0, SCALE - WT_W'(zf3_q)});

  // clamp and drop the extra fraction bits ahead of the divide by 257
  logic [U_W-1:0] u;
  assign u = h4_q[HW-1] ? '0 : h4_q[2*FRAC_BITS-8 +: U_W];

  // reciprocal estimate with one correction step
  logic [Q_W-1:0]   q0, q;
  logic [U_W:0]     rem;
  logic [HEIGHT_W-1:0] qs;
  always_comb begin
    q0  = Q_W'(prod5_q[RECIP_SHIFT +: (PR_W - RECIP_SHIFT)]);
    rem = (U_W+1)'(u5_q) - ((U_W+1)'(q0) * (U_W+1)'(DIV_257));
    q   = (rem >= (U_W+1)'(DIV_257)) ? q0 + 1'b1 : q0;
    qs  = (q > Q_W'(HEIGHT_MAX)) ? HEIGHT_MAX : HEIGHT_W'(q);
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      res_vld_o <= 1'b0;
    end else if (adv) begin
      v1_q      <= re;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      res_vld_o <= v5_q;
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out1_q    <= item_i.outside;
      odd1_q    <= item_i.odd_row;
      xf1_q     <= item_i.xf[FRAC_BITS-1:0];
      zf1_q     <= item_i.zf[FRAC_BITS-1:0];
      bl2_q     <= bl;
      br2_q     <= br;
      tl2_q     <= tl;
      tr2_q     <= tr;
      xf2_q     <= xf1_q;
      zf2_q     <= zf1_q;
      out2_q    <= out1_q;
      top3_q    <= TW'(tl2_q) * TW'(wx0) + TW'(tr2_q) * TW'(wx1);
      bot3_q    <= TW'(bl2_q) * TW'(wx0) + TW'(br2_q) * TW'(wx1);
      zf3_q     <= zf2_q;
      out3_q    <= out2_q;
      h4_q      <= HW'(bot3_q) * HW'(wz0) + HW'(top3_q) * HW'(wz1);
      out4_q    <= out3_q;
      u5_q      <= u;
      prod5_q   <= PR_W'(u) * PR_W'(RECIP_257);
      out5_q    <= out4_q;
      height_o  <= out5_q ? '0 : qs;
      outside_o <= out5_q;
    end
  end

endmodule

/* rtl/hts_checker.sv */
// ----------------------------------------------------------------------------
// hts_checker
// Port-level checks on the height sampler result stream.
// ----------------------------------------------------------------------------
module hts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // outside points report zero height
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0)
    else $error("outside point with nonzero height");

  // height never above 255.0
  a_height_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata <= 16'd65280)
    else $error("height above full scale");

  // no result in the cycle right after reset
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid coming out of reset");

endmodule

bind heightmap_triangle_height_sampler_unit hts_checker u_hts_checker (.*);

/* test/heightmap_triangle_height_sampler_unit_test.sv */
// ----------------------------------------------------------------------------
// heightmap_triangle_height_sampler_unit_test
// Self-checking bench for the terrain height sampler: loads sample patches,
// fires height queries under random backpressure and compares every result
// beat with a directed value or a local split-quad bilinear height predictor.
// ----------------------------------------------------------------------------
module heightmap_triangle_height_sampler_unit_test;
  import hts_pkg::*;

  localparam int FRAC   = 8;
  localparam int ONE    = 1 << FRAC;
  localparam int MAXDIM = 256;

  typedef struct {
    logic [HEIGHT_W-1:0] height;
    logic                outside;
  } height_res_t;

  typedef struct {
    req_e        kind;
    int          idx;
    int          raw;
    int          x;
    int          z;
    bit          typed;
    height_res_t res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_addr_i = 1'b0;
  logic [8:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;  // sample_index, sample_raw, x_coord, z_coord
  logic        s_axis_tuser = 1'b0;  // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;  // height_q8
  logic        m_axis_tuser;  // outside

  // local copy of the map and configuration
  logic [SAMPLE_W-1:0] sample_mem [STORE_DEPTH];
  bit                  sample_set [STORE_DEPTH];
  int                  map_w = 256;
  int                  map_l = 256;

  height_res_t height_fifo[$];
  bit          failed = 1'b0;
  bit          quiet = 1'b0;
  int          beats_sent = 0;
  int          stall_left = 0;

  heightmap_triangle_height_sampler_unit DUT (.*);

  always #5 clk_i = ~clk_i;

  // effective map size after saturation
  function automatic int eff_w();
    return (map_w > MAXDIM) ? MAXDIM : map_w;
  endfunction

  function automatic int eff_l();
    return (map_l > MAXDIM) ? MAXDIM : map_l;
  endfunction

  function automatic bit point_outside(int x, int z);
    return eff_w() < 2 || eff_l() < 2 || x < 0 || z < 0 ||
           x >= (eff_w() - 1) * ONE || z >= (eff_l() - 1) * ONE;
  endfunction

  function automatic int corner_addr(int x, int z, int dx, int dz);
    return ((x >>> FRAC) + dx + ((z >>> FRAC) + dz) * eff_w()) & 16'hffff;
  endfunction

  // a query is safe when outside or all four corners were loaded
  function automatic bit query_safe(int x, int z);
    if (point_outside(x, z)) return 1'b1;
    return sample_set[corner_addr(x, z, 0, 0)] && sample_set[corner_addr(x, z, 1, 0)] &&
           sample_set[corner_addr(x, z, 0, 1)] && sample_set[corner_addr(x, z, 1, 1)];
  endfunction

  // split-quad bilinear height in 8.8
  function automatic height_res_t sample_height(int x, int z);
    height_res_t r;
    longint xf, zf, bl, br, tl, tr, top, bot, h, q;
    if (point_outside(x, z)) begin
      r.height = '0;
      r.outside = 1'b1;
      return r;
    end
    xf = x & (ONE - 1);
    zf = z & (ONE - 1);
    bl = sample_mem[corner_addr(x, z, 0, 0)];
    br = sample_mem[corner_addr(x, z, 1, 0)];
    tl = sample_mem[corner_addr(x, z, 0, 1)];
    tr = sample_mem[corner_addr(x, z, 1, 1)];
    if (((z >>> FRAC) & 1) != 0) begin
      if (zf >= xf) br = bl + tr - tl;
      else tl = tr + bl - br;
    end else begin
      if (xf + zf < ONE) tr = tl + br - bl;
      else bl = tl + br - tr;
    end
    top = tl * (ONE - xf) + tr * xf;
    bot = bl * (ONE - xf) + br * xf;
    h = bot * (ONE - zf) + top * zf;
    if (h < 0) h = 0;
    q = (h * 256) / (257 * longint'(ONE) * ONE);
    if (q > 65280) q = 65280;
    r.height = q[15:0];
    r.outside = 1'b0;
    return r;
  endfunction

  // one input beat; returns after acceptance, store updated, result queued
  task automatic send_beat(req_e kind, int idx, int raw, int x, int z,
                           bit typed = 1'b0, height_res_t res = '{0, 0});
    logic [16:0] xv, zv;
    height_res_t r;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      @(negedge clk_i) s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 13)) @(negedge clk_i);
    end
    xv = x[16:0];
    zv = z[16:0];
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {6'b0, zv, xv, raw[15:0], idx[15:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
    if (kind == REQ_WRITE) begin
      sample_mem[idx & 16'hffff] = raw[15:0];
      sample_set[idx & 16'hffff] = 1'b1;
    end else begin
      r = typed ? res : sample_height($signed(xv), $signed(zv));
      height_fifo.push_back(r);
    end
  endtask

  // let every result come out and the pipeline empty
  task automatic drain();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (height_fifo.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, int val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val[8:0];
    @(negedge clk_i) cfg_we_i <= 1'b0;
    if (idx == CFG_MAP_WIDTH) map_w = val & 9'h1ff;
    else map_l = val & 9'h1ff;
  endtask

  function automatic int rand_raw();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // output side: random stalls, none at the end
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && rst_ni && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    height_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (height_fifo.size() == 0) begin
        $display("%0t: unexpected result beat height=%0d outside=%0b",
                 $time, m_axis_tdata, m_axis_tuser);
        failed = 1'b1;
      end else begin
        e = height_fifo.pop_front();
        if (m_axis_tdata !== e.height) begin
          $display("%0t: height expected %0d actual %0d", $time, e.height, m_axis_tdata);
          failed = 1'b1;
        end
        if (m_axis_tuser !== e.outside) begin
          $display("%0t: outside expected %0b actual %0b", $time, e.outside, m_axis_tuser);
          failed = 1'b1;
        end
      end
    end
  end

  // run limit
  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  // directed rows: corners at full scale, splits, outside points, far corner
  dir_row_t dir_rows [] = '{
    '{REQ_WRITE, 0, 65535, 0, 0, 0, '{0, 0}},
    '{REQ_WRITE, 1, 65535, 0, 0, 0, '{0, 0}},
    '{REQ_WRITE, 256, 65535, 0, 0, 0, '{0, 0}},
    '{REQ_WRITE, 257, 65535, 0, 0, 0, '{0, 0}},
    '{REQ_QUERY, 0, 0, 0, 0, 1, '{65280, 0}},
    '{REQ_QUERY, 0, 0, 128, 128, 1, '{65280, 0}},
    '{REQ_WRITE, 0, 0, 0, 0, 0, '{0, 0}},
    '{REQ_WRITE, 1, 40000, 0, 0, 0, '{0, 0}},
    '{REQ_WRITE, 512, 12345, 0, 0, 0, '{0, 0}},
    '{REQ_WRITE, 513, 0, 0, 0, 0, '{0, 0}},
    '{REQ_QUERY, 0, 0, 64, 32, 0, '{0, 0}},
    '{REQ_QUERY, 0, 0, 200, 150, 0, '{0, 0}},
    '{REQ_QUERY, 0, 0, 40, 456, 0, '{0, 0}},
    '{REQ_QUERY, 0, 0, 200, 296, 0, '{0, 0}},
    '{REQ_QUERY, 0, 0, -1, 0, 1, '{0, 1}},
    '{REQ_QUERY, 0, 0, 0, -65536, 1, '{0, 1}},
    '{REQ_QUERY, 0, 0, 65280, 0, 1, '{0, 1}},
    '{REQ_QUERY, 0, 0, 0, 65280, 1, '{0, 1}},
    '{REQ_QUERY, 0, 0, 65535, 65535, 1, '{0, 1}},
    '{REQ_WRITE, 65278, 0, 0, 0, 0, '{0, 0}},
    '{REQ_WRITE, 65279, 65535, 0, 0, 0, '{0, 0}},
    '{REQ_WRITE, 65534, 65535, 0, 0, 0, '{0, 0}},
    '{REQ_WRITE, 65535, 0, 0, 0, 0, '{0, 0}},
    '{REQ_QUERY, 0, 0, 65279, 65279, 0, '{0, 0}},
    '{REQ_QUERY, 0, 0, 65024, 65024, 0, '{0, 0}}
  };

  // map settings walked by the random part, extremes first
  int cfg_plan [][2] = '{'{2, 2}, '{256, 256}, '{511, 511}, '{0, 5}, '{1, 1},
                          '{3, 256}, '{256, 2}, '{300, 17}};

  initial begin
    int ph, pw, pl, qx, qz, x, z, w, l;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (dir_rows[i])
      send_beat(dir_rows[i].kind, dir_rows[i].idx, dir_rows[i].raw,
                dir_rows[i].x, dir_rows[i].z, dir_rows[i].typed, dir_rows[i].res);
    // hold the sender until the block has gone empty
    drain();

    ph = 0;
    while (beats_sent < 1150) begin
      drain();
      if (beats_sent > 1000) quiet = 1'b1;
      if (ph < cfg_plan.size()) begin
        cfg_write(CFG_MAP_WIDTH, cfg_plan[ph][0]);
        cfg_write(CFG_MAP_LENGTH, cfg_plan[ph][1]);
      end else begin
        cfg_write(CFG_MAP_WIDTH, $urandom_range(2, 40));
        cfg_write(CFG_MAP_LENGTH, $urandom_range(2, 40));
      end
      ph++;
      w = eff_w();
      l = eff_l();
      repeat (4) begin
        // load a small patch of quads, then query mostly inside it
        if (w >= 2 && l >= 2) begin
          qx = $urandom_range(0, w - 2);
          qz = $urandom_range(0, l - 2);
          pw = $urandom_range(1, (w - 1 - qx) < 3 ? (w - 1 - qx) : 3);
          pl = $urandom_range(1, (l - 1 - qz) < 3 ? (l - 1 - qz) : 3);
          for (int j = 0; j <= pl; j++)
            for (int i = 0; i <= pw; i++)
              send_beat(REQ_WRITE, qx + i + (qz + j) * w, rand_raw(), 0, 0);
        end
        repeat (10) begin
          case ($urandom_range(0, 9))
            0: send_beat(REQ_WRITE, $urandom_range(0, 65535), rand_raw(), 0, 0);
            1, 2: begin
              x = $signed(17'($urandom()));
              z = $signed(17'($urandom()));
              if (query_safe(x, z)) send_beat(REQ_QUERY, 0, 0, x, z);
              else send_beat(REQ_QUERY, 0, 0, -x - 1, z);
            end
            default: begin
              if (w >= 2 && l >= 2) begin
                x = qx * ONE + $urandom_range(0, pw * ONE - 1);
                z = qz * ONE + $urandom_range(0, pl * ONE - 1);
              end else begin
                x = $urandom_range(0, 65535);
                z = $urandom_range(0, 65535);
              end
              send_beat(REQ_QUERY, 0, 0, x, z);
            end
          endcase
        end
      end
    end
    drain();
    repeat (30) @(posedge clk_i);
    if (!failed && height_fifo.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/hts_pkg.sv
rtl/hts_ram.sv
rtl/hts_fifo.sv
rtl/hts_front.sv
rtl/hts_back.sv
rtl/heightmap_triangle_height_sampler_unit.sv
rtl/hts_checker.sv
test/heightmap_triangle_height_sampler_unit_test.sv
